### rtl/lsp_pkg.sv
// ----------------------------------------------------------------------------
// lsp_pkg: shared types and constants of the lexeme scanner
// Op codes, scan modes, character constants and the step result struct.
// ----------------------------------------------------------------------------
package lsp_pkg;

  localparam int LineBits    = 20;
  localparam int ColumnBits  = 16;
  localparam int CfgDataBits = (LineBits > ColumnBits) ? LineBits : ColumnBits;
  localparam int CfgIdxBits  = 1;

  typedef enum logic [CfgIdxBits-1:0] {
    CFG_FIRST_LINE   = 1'b0,
    CFG_FIRST_COLUMN = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_NEXT         = 3'd0,
    OP_BEGIN_WORD   = 3'd1,
    OP_BEGIN_STRING = 3'd2,
    OP_BEGIN_NUMBER = 3'd3,
    OP_END_SOURCE   = 3'd4,
    OP_SKIP         = 3'd5,
    OP_RESTART      = 3'd6
  } lsp_op_e;

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_WORD  = 3'd1,
    MODE_STR   = 3'd2,
    MODE_ESC   = 3'd3,
    MODE_INT   = 3'd4,
    MODE_FRAC  = 3'd5,
    MODE_ESIGN = 3'd6,
    MODE_EDIG  = 3'd7
  } scan_mode_e;

  localparam logic [7:0] ChNewline   = 8'h0A;
  localparam logic [7:0] ChTab       = 8'h09;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChUnder     = 8'h5F;
  localparam logic [7:0] ChDot       = 8'h2E;
  localparam logic [7:0] ChLowerE    = 8'h65;
  localparam logic [7:0] ChUpperE    = 8'h45;
  localparam logic [7:0] ChLowerN    = 8'h6E;
  localparam logic [7:0] ChLowerT    = 8'h74;
  localparam logic [7:0] ChPlus      = 8'h2B;
  localparam logic [7:0] ChMinus     = 8'h2D;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       consumed;
    logic       done_res;
  } step_res_t;

  typedef struct packed {
    logic advance;
    logic newline;
    logic restart;
  } pos_ctrl_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

### rtl/lsp_step.sv
// ----------------------------------------------------------------------------
// lsp_step: scan mode step
// Next mode and result flags for one item, from op, byte and current mode.
// ----------------------------------------------------------------------------
module lsp_step (
  input  lsp_pkg::lsp_op_e    op_i,
  input  logic [7:0]          ch_i,
  input  lsp_pkg::scan_mode_e mode_i,
  output lsp_pkg::scan_mode_e mode_next_o,
  output lsp_pkg::step_res_t  res_o
);
  import lsp_pkg::*;

  scan_mode_e m;
  scan_mode_e nxt;
  logic       keep;
  logic       lex_end;
  logic       cons;
  logic       done;
  logic [7:0] ob;

  always_comb begin
    m       = mode_i;
    nxt     = mode_i;
    keep    = 1'b0;
    lex_end = 1'b0;
    cons    = 1'b0;
    done    = 1'b0;
    ob      = ch_i;
    if (op_i == OP_BEGIN_WORD) begin
      m = MODE_WORD;
    end else if (op_i == OP_BEGIN_NUMBER) begin
      m = MODE_INT;
    end
    unique case (op_i)
      OP_BEGIN_STRING: begin
        cons = 1'b1;
        nxt  = MODE_STR;
      end
      OP_END_SOURCE: begin
        done = (mode_i != MODE_IDLE);
        nxt  = MODE_IDLE;
      end
      OP_SKIP: begin
        cons = 1'b1;
      end
      OP_RESTART: begin
        nxt = MODE_IDLE;
      end
      OP_NEXT, OP_BEGIN_WORD, OP_BEGIN_NUMBER: begin
        nxt = m;
        unique case (m)
          MODE_WORD: begin
            if (is_alpha(ch_i) || is_digit(ch_i) || ch_i == ChUnder) keep = 1'b1;
            else lex_end = 1'b1;
          end
          MODE_STR: begin
            if (ch_i == ChQuote || ch_i == ChNewline) begin
              cons = 1'b1;
              done = 1'b1;
              nxt  = MODE_IDLE;
            end else if (ch_i == ChBackslash) begin
              cons = 1'b1;
              nxt  = MODE_ESC;
            end else begin
              keep = 1'b1;
            end
          end
          MODE_ESC: begin
            keep = 1'b1;
            nxt  = MODE_STR;
            if (ch_i == ChLowerN) ob = ChNewline;
            else if (ch_i == ChLowerT) ob = ChTab;
          end
          MODE_INT, MODE_FRAC: begin
            if (is_digit(ch_i)) begin
              keep = 1'b1;
            end else if (ch_i == ChUnder) begin
              cons = 1'b1;
            end else if (ch_i == ChDot && m == MODE_INT) begin
              keep = 1'b1;
              nxt  = MODE_FRAC;
            end else if (ch_i == ChLowerE || ch_i == ChUpperE) begin
              keep = 1'b1;
              nxt  = MODE_ESIGN;
            end else begin
              lex_end = 1'b1;
            end
          end
          MODE_ESIGN: begin
            if (ch_i == ChPlus || ch_i == ChMinus || is_digit(ch_i)) begin
              keep = 1'b1;
              nxt  = MODE_EDIG;
            end else begin
              lex_end = 1'b1;
            end
          end
          MODE_EDIG: begin
            if (is_digit(ch_i)) keep = 1'b1;
            else lex_end = 1'b1;
          end
          MODE_IDLE: begin
            nxt = MODE_IDLE;
          end
        endcase
        if (keep) cons = 1'b1;
        if (lex_end) begin
          done = 1'b1;
          nxt  = MODE_IDLE;
        end
      end
      default: ;
    endcase
  end

  assign mode_next_o      = nxt;
  assign res_o.out_byte   = keep ? ob : 8'h00;
  assign res_o.byte_valid = keep;
  assign res_o.consumed   = cons;
  assign res_o.done_res   = done;

endmodule

### rtl/lsp_position.sv
// ----------------------------------------------------------------------------
// lsp_position: source position tracker
// Restart registers and saturating line and column counters.
// ----------------------------------------------------------------------------
module lsp_position (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lsp_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [lsp_pkg::CfgDataBits-1:0] cfg_data_i,
  input  lsp_pkg::pos_ctrl_t             ctrl_i,
  output logic [lsp_pkg::LineBits-1:0]   line_o,
  output logic [lsp_pkg::ColumnBits-1:0] column_o
);
  import lsp_pkg::*;

  logic [LineBits-1:0]   first_line_q;
  logic [ColumnBits-1:0] first_column_q;
  logic [LineBits-1:0]   line_q, line_d;
  logic [ColumnBits-1:0] column_q, column_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_line_q   <= LineBits'(1);
      first_column_q <= '0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_FIRST_LINE) first_line_q <= cfg_data_i[LineBits-1:0];
      else first_column_q <= cfg_data_i[ColumnBits-1:0];
    end
  end

  always_comb begin
    line_d   = line_q;
    column_d = column_q;
    if (ctrl_i.restart) begin
      line_d   = first_line_q;
      column_d = first_column_q;
    end else if (ctrl_i.advance) begin
      if (ctrl_i.newline) begin
        if (!(&line_q)) line_d = line_q + LineBits'(1);
        column_d = '0;
      end else if (!(&column_q)) begin
        column_d = column_q + ColumnBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_q   <= LineBits'(1);
      column_q <= '0;
    end else begin
      line_q   <= line_d;
      column_q <= column_d;
    end
  end

  assign line_o   = line_q;
  assign column_o = column_q;

endmodule

### rtl/lexeme_scanner_with_position.sv
// ----------------------------------------------------------------------------
// lexeme_scanner_with_position: byte-wise lexeme scanner with line/column
// Result is registered, valid in the cycle after its input transfer; one item
// per cycle unless held by out_ready_i. One mode step feeds the result register.
// Reset: idle mode, line 1, column 0, restart registers 1 and 0, no result.
// ----------------------------------------------------------------------------
module lexeme_scanner_with_position (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration writes
  input  logic                            cfg_we_i,
  input  logic [lsp_pkg::CfgIdxBits-1:0]  cfg_index_i,
  input  logic [lsp_pkg::CfgDataBits-1:0] cfg_data_i,
  // input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      op_i,
  input  logic [7:0]                      ch_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      out_byte_o,
  output logic                            byte_valid_o,
  output logic                            consumed_o,
  output logic                            done_res_o,
  output logic [lsp_pkg::LineBits-1:0]    line_now_o,
  output logic [lsp_pkg::ColumnBits-1:0]  column_now_o
);
  import lsp_pkg::*;

  // Mode register, result register and its valid flag.
  scan_mode_e mode_q, mode_d;
  step_res_t  res_q, step_res;
  logic       out_valid_q, out_valid_d;
  logic       in_xfer;
  lsp_op_e    op;
  pos_ctrl_t  pos_ctrl;

  assign op = lsp_op_e'(op_i);

  // Take a new item whenever the result slot is empty or drains this cycle.
  // The position counters and the mode only move on an input transfer, so
  // they also serve as the position fields of the waiting result.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_xfer    = in_valid_i && in_ready_o;

  lsp_step u_step (
    .op_i        (op),
    .ch_i        (ch_i),
    .mode_i      (mode_q),
    .mode_next_o (mode_d),
    .res_o       (step_res)
  );

  // Advance the position on every consumed byte; restart reloads it.
  assign pos_ctrl.advance = in_xfer && step_res.consumed;
  assign pos_ctrl.newline = (ch_i == ChNewline);
  assign pos_ctrl.restart = in_xfer && (op == OP_RESTART);

  lsp_position u_position (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (pos_ctrl),
    .line_o      (line_now_o),
    .column_o    (column_now_o)
  );

  // Hold the result until its transfer; load a fresh one on each input.
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_xfer) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_xfer) mode_q <= mode_d;
    end
  end

  // Payload of the result register needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer) res_q <= step_res;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = res_q.out_byte;
  assign byte_valid_o = res_q.byte_valid;
  assign consumed_o   = res_q.consumed;
  assign done_res_o   = res_q.done_res;

  // A kept byte is always consumed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_valid_o |-> consumed_o)
    else $error("kept byte not consumed");

  // A lexeme never ends on the item that appends a byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(byte_valid_o && done_res_o))
    else $error("byte appended on ending item");

  // Restart returns the scanner to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && op == OP_RESTART |=> mode_q == MODE_IDLE)
    else $error("restart did not return to idle");

  // Position holds on items that consume nothing and do not restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !step_res.consumed && op != OP_RESTART |=>
      $stable(line_now_o) && $stable(column_now_o))
    else $error("position moved without consumed byte");

endmodule
